/* src/bqpc_pkg.sv */
`timescale 1ns / 1ps
package bqpc_pkg;

  localparam int CAP_W = 13;
  localparam int CNT_W = 7;
  localparam int BYTE_W = 8;
  localparam int CAP_MAX = (1 << CAP_W) - 1;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW = 2;

  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_PEEK   = 2'd1,
    REQ_GET    = 2'd2,
    REQ_REMOVE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    req_t              req;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic             clear;
    logic [CAP_W-1:0] capacity;
  } back_cfg_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] data;
    logic              byte_valid;
    logic              last;
    logic [CAP_W-1:0]  level;
  } res_t;

endpackage

/* src/bqpc_front.sv */
`timescale 1ns / 1ps
module bqpc_front #(
  parameter int MAX_REQUEST = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [15:0]   s_tdata,   // byte_in[7:0], count[14:8], zero[15]
  input  logic [1:0]    s_tuser,   // req_type[1:0]
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output bqpc_pkg::cmd_t cmd
);
  import bqpc_pkg::*;

  cmd_t             q [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr;
  logic [FQ_AW-1:0] rd_ptr;
  logic [FQ_AW:0]   fill;
  logic             push;
  logic             pop;
  cmd_t             cls;
  logic [CNT_W-1:0] raw_count;

  // decode and saturate the request count
  always_comb begin
    raw_count = s_tdata[14:8];
    cls.req = req_t'(s_tuser);
    cls.data = s_tdata[7:0];
    if (32'(raw_count) > MAX_REQUEST) begin
      cls.count = CNT_W'(MAX_REQUEST);
    end else begin
      cls.count = raw_count;
    end
  end

  assign s_tready = (fill != (FQ_AW + 1)'(FQ_DEPTH));
  assign cmd_valid = (fill != '0);
  assign push = s_tvalid && s_tready;
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* src/bqpc_back.sv */
`timescale 1ns / 1ps
module bqpc_back #(
  parameter int DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  bqpc_pkg::back_cfg_t cfg,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  bqpc_pkg::cmd_t     cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output bqpc_pkg::res_t     res
);
  import bqpc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = ((AW > CAP_W) ? AW : CAP_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_STREAM = 2'b10
  } state_t;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] mem_q;

  state_t           state, state_next;
  logic [CAP_W-1:0] held, held_next;
  logic [AW-1:0]    rp, rp_next;
  logic [AW-1:0]    wp, wp_next;
  logic [AW-1:0]    sp, sp_next;
  logic [CNT_W-1:0] rem, rem_next;
  logic [CAP_W-1:0] lvl, lvl_next;

  logic             s1_valid;
  status_t          s1_status, s1_status_next;
  logic             s1_bv, s1_bv_next;
  logic             s1_last, s1_last_next;
  logic [CAP_W-1:0] s1_level, s1_level_next;
  logic             s1_load;
  logic             s1_move;
  logic             issue_ok;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [CAP_W-1:0] n_ext;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p,
                                        input logic [CNT_W-1:0] n,
                                        input logic [CAP_W-1:0] c);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= SW'(c)) begin
      s = s - SW'(c);
    end
    return s[AW-1:0];
  endfunction

  assign s1_move = s1_valid && (!res_valid || res_ready);
  assign issue_ok = !s1_valid || s1_move;
  assign n_ext = CAP_W'(cmd.count);

  always_comb begin
    state_next = state;
    held_next = held;
    rp_next = rp;
    wp_next = wp;
    sp_next = sp;
    rem_next = rem;
    lvl_next = lvl;
    s1_load = 1'b0;
    s1_status_next = ST_OK;
    s1_bv_next = 1'b0;
    s1_last_next = 1'b1;
    s1_level_next = held;
    rd_en = 1'b0;
    rd_addr = rp;
    wr_en = 1'b0;
    cmd_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && issue_ok) begin
          cmd_ready = 1'b1;
          s1_load = 1'b1;
          if (cmd.req == REQ_INSERT) begin
            if (held >= cfg.capacity) begin
              s1_status_next = ST_OVERFLOW;
            end else begin
              wr_en = 1'b1;
              wp_next = adv(wp, CNT_W'(1), cfg.capacity);
              held_next = held + 1'b1;
              s1_level_next = held + 1'b1;
            end
          end else if (n_ext > held) begin
            s1_status_next = ST_SHORT;
          end else if (cmd.req == REQ_REMOVE || cmd.count == '0) begin
            if (cmd.req != REQ_PEEK) begin
              rp_next = adv(rp, cmd.count, cfg.capacity);
              held_next = held - n_ext;
              s1_level_next = held - n_ext;
            end
          end else begin
            rd_en = 1'b1;
            s1_bv_next = 1'b1;
            s1_last_next = (cmd.count == CNT_W'(1));
            if (cmd.req == REQ_GET) begin
              rp_next = adv(rp, cmd.count, cfg.capacity);
              held_next = held - n_ext;
              s1_level_next = held - n_ext;
            end
            lvl_next = s1_level_next;
            sp_next = adv(rp, CNT_W'(1), cfg.capacity);
            rem_next = cmd.count - 1'b1;
            if (cmd.count != CNT_W'(1)) begin
              state_next = S_STREAM;
            end
          end
        end
      end
      S_STREAM: begin
        if (issue_ok) begin
          s1_load = 1'b1;
          rd_en = 1'b1;
          rd_addr = sp;
          s1_bv_next = 1'b1;
          s1_last_next = (rem == CNT_W'(1));
          s1_level_next = lvl;
          sp_next = adv(sp, CNT_W'(1), cfg.capacity);
          rem_next = rem - 1'b1;
          if (rem == CNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= cmd.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held <= '0;
      rp <= '0;
      wp <= '0;
      s1_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.clear) begin
        held <= '0;
        rp <= '0;
        wp <= '0;
      end else begin
        held <= held_next;
        rp <= rp_next;
        wp <= wp_next;
      end
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sp <= sp_next;
    rem <= rem_next;
    lvl <= lvl_next;
    if (s1_load) begin
      s1_status <= s1_status_next;
      s1_bv <= s1_bv_next;
      s1_last <= s1_last_next;
      s1_level <= s1_level_next;
    end
    if (s1_move) begin
      res.status <= s1_status;
      res.data <= s1_bv ? mem_q : '0;
      res.byte_valid <= s1_bv;
      res.last <= s1_last;
      res.level <= s1_level;
    end
  end

endmodule

/* src/byte_queue_peek_consume_unit.sv */
`timescale 1ns / 1ps
// path: command queue, issue stage s1 (single ring read port), result register
// throughput: one result per cycle unless m_tready stalls; insert, remove,
// shortfall and zero count give one result, other peeks and gets count results
// reset: synchronous, clears pointers, level, command queue and output valid;
// capacity returns to the built depth, ring contents stay undefined until written
module byte_queue_peek_consume_unit #(
  parameter int DEPTH = 4096,
  parameter int MAX_REQUEST = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_in[7:0], count[14:8], zero[15]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // byte_out[7:0], level[20:8], zero[23:21]
  output logic [2:0]  m_tuser,   // status[1:0], byte_valid[2]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bqpc_pkg::*;

  localparam int CAP_RESET = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;

  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] cap_wr;
  logic             cfg_wr;
  back_cfg_t        cfg;
  cmd_t             cmd;
  logic             cmd_valid;
  logic             cmd_ready;
  res_t             res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, capacity} : '0;

  always_comb begin
    cap_wr = pwdata[CAP_W-1:0];
    if (cap_wr == '0) begin
      cap_wr = CAP_W'(1);
    end else if (32'(cap_wr) > DEPTH) begin
      cap_wr = CAP_W'(DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RESET);
    end else if (cfg_wr) begin
      capacity <= cap_wr;
    end
  end

  assign cfg.clear = cfg_wr;
  assign cfg.capacity = capacity;

  bqpc_front #(
    .MAX_REQUEST(MAX_REQUEST)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd)
  );

  bqpc_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res(res)
  );

  assign m_tdata = {3'b000, res.level, res.data};
  assign m_tuser = {res.byte_valid, res.status};
  assign m_tlast = res.last;

endmodule

/* src/bqpc_checker.sv */
`timescale 1ns / 1ps
module bqpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import bqpc_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // queue bytes only come with ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK)
    else $error("byte result with error status");

  // error results are always last and carry no byte
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != ST_OK |-> m_tlast && !m_tuser[2] && m_tdata[7:0] == 8'h00)
    else $error("error result malformed");

  a_nobyte_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] |-> m_tlast)
    else $error("non-byte result not last");

  // level stays fixed across a byte run
  a_level_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser[2] && !m_tlast ##1 m_tvalid
      |-> m_tdata[20:8] == $past(m_tdata[20:8]))
    else $error("level changed inside a run");

endmodule

bind byte_queue_peek_consume_unit bqpc_checker u_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser),
  .m_tlast(m_tlast)
);

/* test/tb_byte_queue_peek_consume_unit.sv */
`timescale 1ns / 1ps
module tb_byte_queue_peek_consume_unit;
  import bqpc_pkg::*;

  localparam int RING_DEPTH = 4096;
  localparam int REQ_MAX = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int N_DIRECTED = 21;
  localparam int N_PHASES = 7;
  localparam int PHASE_ITEMS = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  byte_queue_peek_consume_unit #(
    .DEPTH(RING_DEPTH),
    .MAX_REQUEST(REQ_MAX)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the queue
  logic [7:0] shadow_ring [0:RING_DEPTH-1];
  int shadow_rd = 0;
  int shadow_wr = 0;
  int shadow_held = 0;
  int shadow_cap = RING_DEPTH;

  res_t step_results [$];
  res_t pending_results [$];

  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_caps = 0;
  int n_short = 0;
  int n_overflow = 0;
  int cycles = 0;
  int burst_left = 0;
  int ready_pct = 100;

  typedef struct packed {
    logic        is_cfg;
    req_t        req;
    logic [7:0]  data;
    logic [6:0]  cnt;
    logic        typed;
    status_t     st;
    logic [12:0] lvl;
    logic [12:0] cap;
  } row_t;

  row_t dir_rows [0:N_DIRECTED-1] = '{
    '{1'b0, REQ_PEEK,   8'h00, 7'd1,   1'b1, ST_SHORT,    13'd0, 13'd0},
    '{1'b0, REQ_GET,    8'h00, 7'd0,   1'b1, ST_OK,       13'd0, 13'd0},
    '{1'b0, REQ_REMOVE, 8'h00, 7'd0,   1'b1, ST_OK,       13'd0, 13'd0},
    '{1'b0, REQ_PEEK,   8'hff, 7'd0,   1'b1, ST_OK,       13'd0, 13'd0},
    '{1'b0, REQ_INSERT, 8'h00, 7'd0,   1'b1, ST_OK,       13'd1, 13'd0},
    '{1'b0, REQ_INSERT, 8'hff, 7'd127, 1'b1, ST_OK,       13'd2, 13'd0},
    '{1'b0, REQ_INSERT, 8'ha5, 7'd0,   1'b1, ST_OK,       13'd3, 13'd0},
    '{1'b0, REQ_INSERT, 8'h5a, 7'd0,   1'b1, ST_OK,       13'd4, 13'd0},
    '{1'b0, REQ_PEEK,   8'h00, 7'd4,   1'b0, ST_OK,       13'd0, 13'd0},
    '{1'b0, REQ_GET,    8'h00, 7'd2,   1'b0, ST_OK,       13'd0, 13'd0},
    '{1'b0, REQ_PEEK,   8'h00, 7'd127, 1'b1, ST_SHORT,    13'd2, 13'd0},
    '{1'b0, REQ_REMOVE, 8'h00, 7'd1,   1'b1, ST_OK,       13'd1, 13'd0},
    '{1'b0, REQ_GET,    8'h00, 7'd1,   1'b0, ST_OK,       13'd0, 13'd0},
    '{1'b0, REQ_GET,    8'h00, 7'd64,  1'b1, ST_SHORT,    13'd0, 13'd0},
    '{1'b1, REQ_INSERT, 8'h00, 7'd0,   1'b0, ST_OK,       13'd0, 13'd0},
    '{1'b0, REQ_INSERT, 8'h11, 7'd0,   1'b1, ST_OK,       13'd1, 13'd0},
    '{1'b0, REQ_INSERT, 8'h22, 7'd0,   1'b1, ST_OVERFLOW, 13'd1, 13'd0},
    '{1'b0, REQ_GET,    8'h00, 7'd1,   1'b0, ST_OK,       13'd0, 13'd0},
    '{1'b1, REQ_INSERT, 8'h00, 7'd0,   1'b0, ST_OK,       13'd0, 13'd8191},
    '{1'b0, REQ_INSERT, 8'h80, 7'd0,   1'b1, ST_OK,       13'd1, 13'd0},
    '{1'b0, REQ_PEEK,   8'h00, 7'd1,   1'b0, ST_OK,       13'd0, 13'd0}
  };

  int phase_caps [0:N_PHASES-1] = '{2, 3, 17, 100, 4096, 1, 5000};
  int phase_ins_pct [0:N_PHASES-1] = '{50, 50, 55, 60, 70, 50, 65};

  function automatic int ring_next(int p, int n);
    int s;
    s = p + n;
    while (s >= shadow_cap) s -= shadow_cap;
    return s;
  endfunction

  task automatic queue_step(input req_t r, input logic [7:0] b, input logic [6:0] cnt);
    int n;
    int p;
    res_t item;
    step_results.delete();
    n = cnt;
    if (n > REQ_MAX) n = REQ_MAX;
    item.status = ST_OK;
    item.data = '0;
    item.byte_valid = 1'b0;
    item.last = 1'b1;
    if (r == REQ_INSERT) begin
      if (shadow_held >= shadow_cap) begin
        item.status = ST_OVERFLOW;
        n_overflow++;
      end else begin
        shadow_ring[shadow_wr] = b;
        shadow_wr = ring_next(shadow_wr, 1);
        shadow_held++;
      end
      item.level = shadow_held[12:0];
      step_results.push_back(item);
    end else if (n > shadow_held) begin
      item.status = ST_SHORT;
      n_short++;
      item.level = shadow_held[12:0];
      step_results.push_back(item);
    end else if (r == REQ_REMOVE || n == 0) begin
      if (r != REQ_PEEK) begin
        shadow_rd = ring_next(shadow_rd, n);
        shadow_held -= n;
      end
      item.level = shadow_held[12:0];
      step_results.push_back(item);
    end else begin
      p = shadow_rd;
      if (r == REQ_GET) begin
        shadow_rd = ring_next(shadow_rd, n);
        shadow_held -= n;
      end
      for (int i = 0; i < n; i++) begin
        item.data = shadow_ring[p];
        item.byte_valid = 1'b1;
        item.last = (i == n - 1);
        item.level = shadow_held[12:0];
        step_results.push_back(item);
        p = ring_next(p, 1);
      end
    end
  endtask

  // one request transaction; bursts of back-to-back items with random gaps
  task automatic send_request(input req_t r, input logic [7:0] b, input logic [6:0] cnt,
                              input logic typed, input status_t st, input logic [12:0] lvl);
    int gap;
    res_t item;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r;
    s_tdata <= {1'b0, cnt, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    n_requests++;
    queue_step(r, b, cnt);
    if (typed) begin
      item.status = st;
      item.data = '0;
      item.byte_valid = 1'b0;
      item.last = 1'b1;
      item.level = lvl;
      pending_results.push_back(item);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  task automatic drain_results;
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [12:0] value);
    int v;
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(int'(REG_CAPACITY) * 4);
    pwdata <= {19'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    v = value;
    if (v < 1) v = 1;
    if (v > RING_DEPTH) v = RING_DEPTH;
    shadow_cap = v;
    shadow_rd = 0;
    shadow_wr = 0;
    shadow_held = 0;
    n_caps++;
    // read back the register
    @(posedge clk);
    if (prdata != 32'(v)) begin
      $error("capacity: expected %0d, actual %0d", v, prdata);
      errors++;
    end
  endtask

  res_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser[1:0] != want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tuser[1:0]);
          errors++;
        end
        if (m_tdata[7:0] != want.data) begin
          $error("byte_out: expected %0h, actual %0h", want.data, m_tdata[7:0]);
          errors++;
        end
        if (m_tuser[2] != want.byte_valid) begin
          $error("byte_valid: expected %0d, actual %0d", want.byte_valid, m_tuser[2]);
          errors++;
        end
        if (m_tlast != want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_tlast);
          errors++;
        end
        if (m_tdata[20:8] != want.level) begin
          $error("level: expected %0d, actual %0d", want.level, m_tdata[20:8]);
          errors++;
        end
      end
    end
    // receiver backpressure pattern, with a randomly chosen ready rate
    if (cycles % 50 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 40;
        default: ready_pct = 10;
      endcase
    end
    m_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("byte_queue_peek_consume_unit verification failed");
      $finish;
    end
  end

  req_t       rnd_req;
  logic [7:0] rnd_data;
  logic [6:0] rnd_cnt;
  int         hi;

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int k = 0; k < N_DIRECTED; k++) begin
      if (dir_rows[k].is_cfg) begin
        write_capacity(dir_rows[k].cap);
      end else begin
        send_request(dir_rows[k].req, dir_rows[k].data, dir_rows[k].cnt,
                     dir_rows[k].typed, dir_rows[k].st, dir_rows[k].lvl);
      end
    end

    // random phases, one capacity setting each
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_capacity(13'(phase_caps[ph]));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        rnd_data = 8'($urandom);
        if ($urandom_range(0, 99) < phase_ins_pct[ph]) begin
          rnd_req = REQ_INSERT;
          rnd_cnt = 7'($urandom);
        end else begin
          rnd_req = req_t'($urandom_range(1, 3));
          hi = (shadow_held < REQ_MAX) ? shadow_held : REQ_MAX;
          if (shadow_held > REQ_MAX && $urandom_range(0, 4) == 0)
            rnd_cnt = 7'($urandom_range(REQ_MAX + 1, 127));
          else if (hi > 0 && $urandom_range(0, 9) < 7)
            rnd_cnt = 7'($urandom_range(1, hi));
          else
            rnd_cnt = 7'($urandom_range(0, 127));
        end
        send_request(rnd_req, rnd_data, rnd_cnt, 1'b0, ST_OK, 13'd0);
      end
    end

    drain_results();
    $display("covered %0d requests and %0d result transactions over %0d capacity settings",
             n_requests, n_results, n_caps);
    $display("shortfall requests %0d, overflowed inserts %0d", n_short, n_overflow);
    if (errors == 0) begin
      $display("byte_queue_peek_consume_unit verification clean");
    end else begin
      $display("byte_queue_peek_consume_unit verification failed");
    end
    $finish;
  end

endmodule
